// File: hw/rtl/tmip_pkg.sv
// Shared types, constants and CRC helper for the tile map image parser.
`timescale 1ns / 1ps

package tmip_pkg;

    localparam logic [31:0] MAGIC_WORD   = 32'h574D_6170;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_TILES    = 32'd16777216;
    localparam logic [15:0] MAX_LAYERS   = 16'd3;

    localparam logic [31:0] HEADER_BYTES = 32'd28;
    localparam logic [31:0] CRC_START    = 32'd8;
    localparam logic [31:0] POS_MAGIC    = 32'd3;
    localparam logic [31:0] POS_CHECKSUM = 32'd7;
    localparam logic [31:0] POS_VERSION  = 32'd11;
    localparam logic [31:0] POS_SIZE     = 32'd15;
    localparam logic [31:0] POS_DIMS     = 32'd19;
    localparam logic [31:0] POS_LAYERS   = 32'd21;
    localparam logic [31:0] POS_EVENTS   = 32'd23;
    localparam logic [31:0] POS_COMP     = 32'd27;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT_HDR = 4'd1;
    localparam logic [3:0] ST_MAGIC     = 4'd2;
    localparam logic [3:0] ST_CRC       = 4'd3;
    localparam logic [3:0] ST_VERSION   = 4'd4;
    localparam logic [3:0] ST_SIZE      = 4'd5;
    localparam logic [3:0] ST_LAYERS    = 4'd6;
    localparam logic [3:0] ST_EVENTS    = 4'd7;
    localparam logic [3:0] ST_COMP      = 4'd8;
    localparam logic [3:0] ST_DATA      = 4'd9;

    localparam logic       KIND_TILE    = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [7:0] CFG_EXPECTED_VERSION = 8'd0;
    localparam logic [7:0] CFG_RAW_MODE_CODE    = 8'd1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic        kind;
        logic [1:0]  layer;
        logic [23:0] index;
        logic [15:0] value;
        logic [15:0] width;
        logic [15:0] height;
        logic [3:0]  status;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [31:0] expected_version;
        logic [31:0] raw_mode_code;
    } t_cfg;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/tmip_core.sv
// Per-byte header check, CRC, tile word assembly and final status.
`timescale 1ns / 1ps

module tmip_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  tmip_pkg::t_cfg i_cfg,
    output logic           o_tile_valid,
    output tmip_pkg::t_item o_tile,
    output logic           o_status_valid,
    output tmip_pkg::t_item o_status
);
    import tmip_pkg::*;

    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_checksum, n_checksum;
    logic [31:0] r_data_size, n_data_size;
    logic [31:0] r_wh, n_wh;
    logic [31:0] r_area, n_area;
    logic [1:0]  r_layer_count, n_layer_count;
    logic [23:0] r_tile_counter, n_tile_counter;
    logic [7:0]  r_high, n_high;
    logic [3:0]  r_error, n_error;
    logic [1:0]  r_cur_layer, n_cur_layer;
    logic [31:0] r_version, n_version;
    logic [15:0] r_layers, n_layers;
    logic [15:0] r_events, n_events;

    logic [31:0] pos;
    logic        done_cur;
    logic        done_new;
    logic [24:0] tile_next;
    logic [3:0]  hdr_err;
    logic [3:0]  st;
    logic [31:0] payload;

    assign pos = r_byte_count;

    always_comb begin
        n_byte_count   = r_byte_count;
        n_crc          = r_crc;
        n_shift        = r_shift;
        n_checksum     = r_checksum;
        n_data_size    = r_data_size;
        n_wh           = r_wh;
        n_area         = r_area;
        n_layer_count  = r_layer_count;
        n_tile_counter = r_tile_counter;
        n_high         = r_high;
        n_error        = r_error;
        n_cur_layer    = r_cur_layer;
        n_version      = r_version;
        n_layers       = r_layers;
        n_events       = r_events;
        hdr_err        = ST_OK;
        st             = ST_OK;
        done_new       = 1'b0;
        payload        = 32'd0;

        o_tile_valid   = 1'b0;
        o_status_valid = 1'b0;

        done_cur  = (r_area == 32'd0) || ({1'b0, r_cur_layer} >= {1'b0, r_layer_count});
        tile_next = {1'b0, r_tile_counter} + 25'd1;

        if (i_valid) begin
            if (pos < HEADER_BYTES) begin
                n_shift = {r_shift[23:0], i_byte};
                if (pos >= CRC_START) begin
                    n_crc = crc_byte(r_crc, i_byte);
                end
                case (pos)
                    POS_CHECKSUM: n_checksum  = n_shift;
                    POS_VERSION:  n_version   = n_shift;
                    POS_SIZE:     n_data_size = n_shift;
                    POS_DIMS: begin
                        n_wh   = n_shift;
                        n_area = {16'd0, n_shift[31:16]} * {16'd0, n_shift[15:0]};
                    end
                    POS_LAYERS:   n_layers    = n_shift[15:0];
                    POS_EVENTS:   n_events    = n_shift[15:0];
                    POS_COMP: begin
                        if (r_error != ST_OK)                                 hdr_err = r_error;
                        else if (r_checksum != ~n_crc)                        hdr_err = ST_CRC;
                        else if (r_version != i_cfg.expected_version)         hdr_err = ST_VERSION;
                        else if (r_layers < 16'd1 || r_layers > MAX_LAYERS)   hdr_err = ST_LAYERS;
                        else if (r_events != 16'd0)                           hdr_err = ST_EVENTS;
                        else if (n_shift != i_cfg.raw_mode_code)              hdr_err = ST_COMP;
                        else if (r_area > MAX_TILES)                          hdr_err = ST_DATA;
                        else                                                  hdr_err = ST_OK;
                        n_error       = hdr_err;
                        n_layer_count = (hdr_err == ST_OK) ? r_layers[1:0] : 2'd0;
                    end
                    default: ;
                endcase
                if (pos == POS_MAGIC && n_shift != MAGIC_WORD) begin
                    n_error = ST_MAGIC;
                end
            end else if (r_error == ST_OK && !done_cur) begin
                if (!pos[0]) begin
                    n_high = i_byte;
                end else begin
                    o_tile_valid = 1'b1;
                    if ({7'd0, tile_next} >= r_area) begin
                        n_tile_counter = 24'd0;
                        n_cur_layer    = r_cur_layer + 2'd1;
                    end else begin
                        n_tile_counter = tile_next[23:0];
                    end
                end
            end

            if (r_byte_count != 32'hFFFF_FFFF) begin
                n_byte_count = r_byte_count + 32'd1;
            end

            if (i_last) begin
                o_status_valid = 1'b1;
                done_new = (n_area == 32'd0) ||
                           ({1'b0, n_cur_layer} >= {1'b0, n_layer_count});
                payload  = n_byte_count - HEADER_BYTES;
                if (pos < POS_COMP)                                      st = ST_SHORT_HDR;
                else if (n_error == ST_MAGIC || n_error == ST_CRC ||
                         n_error == ST_VERSION)                          st = n_error;
                else if (n_byte_count == 32'hFFFF_FFFF ||
                         payload != n_data_size)                         st = ST_SIZE;
                else if (n_error != ST_OK)                               st = n_error;
                else if (!done_new)                                      st = ST_DATA;
                else                                                     st = ST_OK;
            end
        end

        o_tile.kind   = KIND_TILE;
        o_tile.layer  = r_cur_layer;
        o_tile.index  = r_tile_counter;
        o_tile.value  = {r_high, i_byte};
        o_tile.width  = n_wh[31:16];
        o_tile.height = n_wh[15:0];
        o_tile.status = ST_OK;
        o_tile.last   = 1'b0;

        o_status.kind   = KIND_STATUS;
        o_status.layer  = 2'd0;
        o_status.index  = 24'd0;
        o_status.value  = 16'd0;
        o_status.width  = n_wh[31:16];
        o_status.height = n_wh[15:0];
        o_status.status = st;
        o_status.last   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_byte_count   <= 32'd0;
            r_crc          <= CRC_INIT;
            r_shift        <= 32'd0;
            r_checksum     <= 32'd0;
            r_data_size    <= 32'd0;
            r_wh           <= 32'd0;
            r_area         <= 32'd0;
            r_layer_count  <= 2'd0;
            r_tile_counter <= 24'd0;
            r_high         <= 8'd0;
            r_error        <= ST_OK;
            r_cur_layer    <= 2'd0;
            r_version      <= 32'd0;
            r_layers       <= 16'd0;
            r_events       <= 16'd0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_crc          <= n_crc;
            r_shift        <= n_shift;
            r_checksum     <= n_checksum;
            r_data_size    <= n_data_size;
            r_wh           <= n_wh;
            r_area         <= n_area;
            r_layer_count  <= n_layer_count;
            r_tile_counter <= n_tile_counter;
            r_high         <= n_high;
            r_error        <= n_error;
            r_cur_layer    <= n_cur_layer;
            r_version      <= n_version;
            r_layers       <= n_layers;
            r_events       <= n_events;
        end
    end

endmodule

// File: hw/rtl/tmip_queue.sv
// Small result queue that takes up to two items per cycle and drains one while i_ready is high.
`timescale 1ns / 1ps

module tmip_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_a,
    input  tmip_pkg::t_item i_item_a,
    input  logic            i_push_b,
    input  tmip_pkg::t_item i_item_b,
    output logic            o_room,
    output logic            o_valid,
    output tmip_pkg::t_item o_item,
    input  logic            i_ready
);
    import tmip_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wptr, n_wptr;
    logic [Q_AW-1:0]     r_rptr, n_rptr;
    logic [Q_CW-1:0]     r_count, n_count;
    logic [Q_AW-1:0]     addr_b;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign o_room  = (r_count <= Q_CW'(Q_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign addr_b  = i_push_a ? r_wptr + Q_AW'(1) : r_wptr;

    always_comb begin
        n_wptr  = r_wptr + Q_AW'(i_push_a) + Q_AW'(i_push_b);
        n_rptr  = r_rptr + Q_AW'(pop);
        n_count = r_count + Q_CW'(i_push_a) + Q_CW'(i_push_b) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_item_a;
        end
        if (i_push_b) begin
            r_mem[addr_b] <= i_item_b;
        end
    end

endmodule

// File: hw/rtl/tile_map_image_parser.sv
// Top level of the tile map image parser: input register, core, result queue.
`timescale 1ns / 1ps

// Accepts one image byte per cycle. The header (28 bytes: magic, CRC-32 over bytes 8..27,
// version, data size, width, height, layers, events, compression) is checked as it streams;
// then each pair of bytes leaves as a tile word with its layer and row-major index. The byte
// marked tlast adds a final status item (tuser = 1) and returns the parser to its start state
// for the next image; the registers are kept. A byte's result passes through the input register
// and a result queue entry. A byte is taken every cycle while the four-entry result queue has
// room for two items, so the rate is one byte per cycle as long as the output side drains one
// item per cycle; the byte step (CRC update, field capture and tile counter compare) is
// combinational in the core. Write the registers only while no image is in flight.
module tile_map_image_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // layer_number, tile_index, tile_value, width_tiles,
                                          // height_tiles, status_code, zero pad
    output logic        o_m_axis_tuser,   // item_kind
    output logic        o_m_axis_tlast,   // last_result
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tmip_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_cfg        r_cfg;
    logic        consume;
    logic        room;
    logic        tile_valid;
    logic        status_valid;
    t_item       tile_item;
    t_item       status_item;
    t_item       out_item;

    assign o_cfg_ready     = 1'b1;
    assign consume         = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= 32'd0;
            r_cfg.raw_mode_code    <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data;
                CFG_RAW_MODE_CODE:    r_cfg.raw_mode_code    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    tmip_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (consume),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_cfg          (r_cfg),
        .o_tile_valid   (tile_valid),
        .o_tile         (tile_item),
        .o_status_valid (status_valid),
        .o_status       (status_item)
    );

    tmip_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (tile_valid),
        .i_item_a (tile_item),
        .i_push_b (status_valid),
        .i_item_b (status_item),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .o_item   (out_item),
        .i_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, out_item.status, out_item.height, out_item.width,
                             out_item.value, out_item.index, out_item.layer};
    assign o_m_axis_tuser = out_item.kind;
    assign o_m_axis_tlast = out_item.last;

endmodule
